/* design/owse_pkg.sv */
// Package of shared types and constants for the 1-Wire search-ROM decision engine.
package owse_pkg;

  // Address and table sizing.
  localparam int ADDR_BITS     = 64;
  localparam int POS_W         = 7;
  localparam int TABLE_ENTRIES = 8;
  localparam int TBL_IW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W        = 3;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 3;

  // Stream word widths, padded to whole bytes.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // Reset value of the command byte register (search ROM).
  localparam logic [7:0] SEARCH_ROM_CMD = 8'hF0;

  // Input word kinds.
  typedef enum logic [CMD_W-1:0] {
    CMD_NEW_SEARCH = 3'd0,
    CMD_NEXT_PASS  = 3'd1,
    CMD_BIT_PAIR   = 3'd2,
    CMD_READ_SLOT  = 3'd3,
    CMD_WRITE_SLOT = 3'd4
  } cmd_t;

  // Result word kinds.
  typedef enum logic [STATUS_W-1:0] {
    ST_BIT_STEP   = 3'd0,
    ST_PASS_START = 3'd1,
    ST_NO_DEVICE  = 3'd2,
    ST_READ_ERROR = 3'd3,
    ST_NEW_STORED = 3'd4,
    ST_NEXT_PASS  = 3'd5,
    ST_FINISHED   = 3'd6,
    ST_SLOT_DATA  = 3'd7
  } status_t;

endpackage

/* design/onewire_rom_search_engine_unit.sv */
// Top level of the 1-Wire search-ROM decision engine with its table of known addresses.
//
//  Channel | Direction | Handshake          | Contents
//  in_     | input     | in_tvalid/tready   | tuser: cmd; tdata: presence .. entry_value
//  out_    | output    | out_tvalid/tready  | tuser: status; tdata: direction .. slot; tlast
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data: search command byte
//
// Each input word is decided combinationally and its result lands in the output register.
// The word that ends a pass also starts a table scan: one shared 64-bit compare looks at
// one table entry per cycle until it finds an empty or matching entry or reaches the last.
// Reset (rst_n, synchronous) empties the table at once through per-entry valid bits
// and restores the command byte to 0xF0. The input is ready only when the sequencer is
// idle and the output register is free or being emptied; a stalled output holds its
// word and stops further input.
module onewire_rom_search_engine_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd
  input  logic [owse_pkg::CMD_W-1:0]      in_tuser,
  // presence, bit_a, bit_b, slot_index[2:0], entry_value[63:0], zero padding
  input  logic [owse_pkg::IN_DATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status
  output logic [owse_pkg::STATUS_W-1:0]   out_tuser,
  // direction_bit, command_byte[7:0], rom_address[63:0], slot_used[2:0], zero padding
  output logic [owse_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // Configuration.
  input  logic                            cfg_wr_en,
  input  logic [7:0]                      cfg_wr_data
);
  import owse_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(ADDR_BITS);
  localparam logic [TBL_IW-1:0] IDX_LAST = TBL_IW'(TABLE_ENTRIES - 1);

  // Input word fields.
  logic                 in_presence;
  logic                 in_bit_a;
  logic                 in_bit_b;
  logic [SLOT_W-1:0]    in_slot;
  logic [ADDR_BITS-1:0] in_entry;
  logic                 in_fire;
  logic                 out_free;

  assign in_presence = in_tdata[0];
  assign in_bit_a    = in_tdata[1];
  assign in_bit_b    = in_tdata[2];
  assign in_slot     = in_tdata[5:3];
  assign in_entry    = in_tdata[69:6];

  // Registers.
  state_t               state_r, state_nxt;
  logic [7:0]           search_cmd_r, search_cmd_nxt;
  logic [ADDR_BITS-1:0] search_bits_r, search_bits_nxt;
  logic [POS_W-1:0]     last_disc_r, last_disc_nxt;
  logic [POS_W-1:0]     pass_marker_r, pass_marker_nxt;
  logic [POS_W-1:0]     bit_pos_r, bit_pos_nxt;
  logic                 pass_active_r, pass_active_nxt;
  logic [TBL_IW-1:0]    scan_idx_r, scan_idx_nxt;
  status_t              pend_status_r, pend_status_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_dir_r, out_dir_nxt;
  logic [7:0]           out_cmdb_r, out_cmdb_nxt;
  logic [ADDR_BITS-1:0] out_addr_r, out_addr_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                 out_last_r, out_last_nxt;

  // Address table: data without reset, valid bits cleared by reset.
  logic [ADDR_BITS-1:0]     tbl_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tbl_vld_r;
  logic                     tbl_we;
  logic [TBL_IW-1:0]        tbl_wa;
  logic [ADDR_BITS-1:0]     tbl_wd;
  logic [TBL_IW-1:0]        tbl_ra;
  logic [ADDR_BITS-1:0]     tbl_rd;
  logic                     slot_in_range;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign slot_in_range = (32'(in_slot) < TABLE_ENTRIES);

  // One read port: the scan counter while scanning, else the requested slot.
  assign tbl_ra = (state_r == S_SCAN) ? scan_idx_r : TBL_IW'(in_slot);
  assign tbl_rd = tbl_vld_r[tbl_ra] ? tbl_mem[tbl_ra] : '0;

  // Direction decision for one bit pair.
  logic [5:0]           bit_idx;
  logic                 bit_ok;
  logic                 pass_end;
  logic [ADDR_BITS-1:0] sb_step;
  logic [POS_W-1:0]     pm_step;
  logic                 dir_step;

  assign bit_idx  = bit_pos_r[5:0] - 6'd1;
  assign bit_ok   = pass_active_r && (bit_pos_r != '0) && (bit_pos_r <= POS_LAST);
  assign pass_end = (bit_pos_r == POS_LAST);

  always_comb begin
    sb_step = search_bits_r;
    pm_step = pass_marker_r;
    if (in_bit_a || in_bit_b) begin
      sb_step[bit_idx] = in_bit_a;
    end else if (bit_pos_r == last_disc_r) begin
      sb_step[bit_idx] = 1'b1;
    end else if (bit_pos_r > last_disc_r) begin
      sb_step[bit_idx] = 1'b0;
      pm_step          = bit_pos_r;
    end else if (!search_bits_r[bit_idx]) begin
      pm_step = bit_pos_r;
    end
    dir_step = sb_step[bit_idx];
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt       = state_r;
    search_cmd_nxt  = search_cmd_r;
    search_bits_nxt = search_bits_r;
    last_disc_nxt   = last_disc_r;
    pass_marker_nxt = pass_marker_r;
    bit_pos_nxt     = bit_pos_r;
    pass_active_nxt = pass_active_r;
    scan_idx_nxt    = scan_idx_r;
    pend_status_nxt = pend_status_r;
    pend_slot_nxt   = pend_slot_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_dir_nxt     = out_dir_r;
    out_cmdb_nxt    = out_cmdb_r;
    out_addr_nxt    = out_addr_r;
    out_slot_nxt    = out_slot_r;
    out_last_nxt    = out_last_r;
    tbl_we          = 1'b0;
    tbl_wa          = TBL_IW'(in_slot);
    tbl_wd          = in_entry;

    if (cfg_wr_en) begin
      search_cmd_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Defaults for a result word; fields without meaning stay zero.
          out_dir_nxt  = 1'b0;
          out_cmdb_nxt = '0;
          out_addr_nxt = '0;
          out_slot_nxt = '0;
          out_last_nxt = 1'b1;
          case (cmd_t'(in_tuser))
            CMD_NEW_SEARCH, CMD_NEXT_PASS: begin
              if (cmd_t'(in_tuser) == CMD_NEW_SEARCH) begin
                search_bits_nxt = '0;
                last_disc_nxt   = '0;
              end
              out_valid_nxt = 1'b1;
              if (!in_presence) begin
                pass_active_nxt = 1'b0;
                out_status_nxt  = ST_NO_DEVICE;
              end else begin
                bit_pos_nxt     = POS_W'(1);
                pass_marker_nxt = '0;
                pass_active_nxt = 1'b1;
                out_status_nxt  = ST_PASS_START;
                out_cmdb_nxt    = search_cmd_r;
              end
            end
            CMD_BIT_PAIR: begin
              if (bit_ok) begin
                out_valid_nxt = 1'b1;
                if (in_bit_a && in_bit_b) begin
                  // Both bits high: the pass is abandoned.
                  out_status_nxt  = ST_READ_ERROR;
                  out_dir_nxt     = search_bits_r[bit_idx];
                  pass_marker_nxt = '0;
                  last_disc_nxt   = '0;
                  pass_active_nxt = 1'b0;
                end else begin
                  search_bits_nxt = sb_step;
                  pass_marker_nxt = pm_step;
                  out_status_nxt  = ST_BIT_STEP;
                  out_dir_nxt     = dir_step;
                  if (!pass_end) begin
                    bit_pos_nxt = bit_pos_r + POS_W'(1);
                  end else begin
                    bit_pos_nxt     = POS_LAST + POS_W'(1);
                    pass_active_nxt = 1'b0;
                    last_disc_nxt   = pm_step;
                    out_last_nxt    = 1'b0;
                    scan_idx_nxt    = '0;
                    state_nxt       = S_SCAN;
                  end
                end
              end
            end
            CMD_READ_SLOT: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_SLOT_DATA;
              out_addr_nxt   = slot_in_range ? tbl_rd : '0;
            end
            CMD_WRITE_SLOT: begin
              tbl_we = slot_in_range;
            end
            default: begin
            end
          endcase
        end
      end

      // One table entry per cycle through the shared compare.
      S_SCAN: begin
        if (tbl_rd == '0) begin
          tbl_we          = 1'b1;
          tbl_wa          = scan_idx_r;
          tbl_wd          = search_bits_r;
          pend_status_nxt = ST_NEW_STORED;
          pend_slot_nxt   = SLOT_W'(scan_idx_r);
          state_nxt       = S_EMIT;
        end else if ((tbl_rd == search_bits_r) || (scan_idx_r == IDX_LAST)) begin
          pend_status_nxt = (last_disc_r == '0) ? ST_FINISHED : ST_NEXT_PASS;
          pend_slot_nxt   = '0;
          state_nxt       = S_EMIT;
        end else begin
          scan_idx_nxt = scan_idx_r + TBL_IW'(1);
        end
      end

      // Hand the pass-end word to the output register once it is free.
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_dir_nxt    = 1'b0;
          out_cmdb_nxt   = '0;
          out_addr_nxt   = search_bits_r;
          out_slot_nxt   = pend_slot_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      search_cmd_r  <= SEARCH_ROM_CMD;
      search_bits_r <= '0;
      last_disc_r   <= '0;
      pass_marker_r <= '0;
      bit_pos_r     <= POS_W'(1);
      pass_active_r <= 1'b0;
      scan_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      search_cmd_r  <= search_cmd_nxt;
      search_bits_r <= search_bits_nxt;
      last_disc_r   <= last_disc_nxt;
      pass_marker_r <= pass_marker_nxt;
      bit_pos_r     <= bit_pos_nxt;
      pass_active_r <= pass_active_nxt;
      scan_idx_r    <= scan_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    pend_status_r <= pend_status_nxt;
    pend_slot_r   <= pend_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_dir_r     <= out_dir_nxt;
    out_cmdb_r    <= out_cmdb_nxt;
    out_addr_r    <= out_addr_nxt;
    out_slot_r    <= out_slot_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Table storage and its valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[tbl_wa] <= 1'b1;
    end
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  // Output word packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_slot_r, out_addr_r, out_cmdb_r, out_dir_r};

  // The input is never taken while a scan or a held pass-end word is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input accepted while the sequencer is busy");

  // A pass-ending bit pair always starts the table scan.
  a_pass_end_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == CMD_BIT_PAIR) && bit_ok && !(in_bit_a && in_bit_b) && pass_end)
    |=> (state_r == S_SCAN) && out_valid_r && !out_last_r)
    else $error("pass end did not start the table scan");

  // While a pass runs the bit position stays within the address.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pass_active_r |-> ((bit_pos_r != '0) && (bit_pos_r <= POS_LAST)))
    else $error("bit position outside the address during a pass");

  // Only the first word of a pass end goes out without the last flag.
  a_last_only_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == ST_BIT_STEP))
    else $error("word without last flag is not a bit step");

  // The scan index stays inside the table.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (32'(scan_idx_r) < TABLE_ENTRIES))
    else $error("table scan ran past the last entry");

endmodule

/* verif/tb_onewire_rom_search_engine_unit.sv */
// Self-checking testbench for the 1-Wire search-ROM engine, driven by emulated device populations.
`timescale 1ns / 100ps

module tb_onewire_rom_search_engine_unit;
  import owse_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int MAX_DEVICES   = 12;

  // One input word, unpacked into its fields.
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic                 presence;
    logic                 a;
    logic                 b;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_BITS-1:0] value;
  } bus_word_t;

  // One result word, unpacked into its fields.
  typedef struct packed {
    status_t              status;
    logic                 dir;
    logic [7:0]           cbyte;
    logic [ADDR_BITS-1:0] addr;
    logic [SLOT_W-1:0]    slot;
    logic                 last;
  } search_result_t;

  // Search state and address table as the engine should hold them.
  typedef struct packed {
    logic [7:0]                                cmd_byte;
    logic [ADDR_BITS-1:0]                      bits;
    logic [POS_W-1:0]                          last_disc;
    logic [POS_W-1:0]                          marker;
    logic [POS_W-1:0]                          pos;
    logic                                      active;
    logic [TABLE_ENTRIES-1:0][ADDR_BITS-1:0]   tbl;
  } engine_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [CMD_W-1:0]      in_tuser    = '0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [STATUS_W-1:0]   out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en   = 1'b0;
  logic [7:0]            cfg_wr_data = '0;

  onewire_rom_search_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  engine_t          model_engine;
  engine_t          gen_engine;
  bus_word_t        bus_words[$];
  search_result_t   awaited_results[$];
  bus_word_t        word_on_bus;
  logic [ADDR_BITS-1:0] devices[$];
  int               words_issued   = 0;
  int               words_accepted = 0;
  int               words_counted  = 0;
  int               mismatches     = 0;
  int               send_gap       = 0;
  int               rx_wait        = 0;
  int               cycles_run     = 0;
  bit               tx_idle        = 1'b1;
  bit               rx_idle        = 1'b1;
  bit               hold_off_req   = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic engine_t engine_reset();
    engine_t e;
    e          = '0;
    e.cmd_byte = SEARCH_ROM_CMD;
    e.pos      = POS_W'(1);
    return e;
  endfunction

  // Works out the result words of one input word and advances the search state.
  function automatic int search_step(inout engine_t e, input bus_word_t w,
                                     output search_result_t lead,
                                     output search_result_t tail);
    logic [5:0] idx;
    bit         matched;
    lead    = '0;
    tail    = '0;
    matched = 1'b0;
    idx     = 6'(e.pos - POS_W'(1));
    case (w.cmd)
      CMD_NEW_SEARCH, CMD_NEXT_PASS: begin
        if (w.cmd == CMD_NEW_SEARCH) begin
          e.bits      = '0;
          e.last_disc = '0;
        end
        lead.last = 1'b1;
        if (!w.presence) begin
          e.active    = 1'b0;
          lead.status = ST_NO_DEVICE;
        end else begin
          e.pos       = POS_W'(1);
          e.marker    = '0;
          e.active    = 1'b1;
          lead.status = ST_PASS_START;
          lead.cbyte  = e.cmd_byte;
        end
        return 1;
      end
      CMD_BIT_PAIR: begin
        if (!e.active || e.pos < 1 || e.pos > ADDR_BITS) return 0;
        lead.last = 1'b1;
        // Both bits high means nobody answered properly: abandon the pass.
        if (w.a && w.b) begin
          lead.status = ST_READ_ERROR;
          lead.dir    = e.bits[idx];
          e.marker    = '0;
          e.last_disc = '0;
          e.active    = 1'b0;
          return 1;
        end
        if (w.a || w.b) e.bits[idx] = w.a;
        else if (e.pos == e.last_disc) e.bits[idx] = 1'b1;
        else if (e.pos > e.last_disc) begin
          e.bits[idx] = 1'b0;
          e.marker    = e.pos;
        end else if (!e.bits[idx]) e.marker = e.pos;
        lead.status = ST_BIT_STEP;
        lead.dir    = e.bits[idx];
        if (e.pos < ADDR_BITS) begin
          e.pos = e.pos + POS_W'(1);
          return 1;
        end
        // Last bit of the pass: a second word reports what became of the address.
        e.pos       = POS_W'(ADDR_BITS + 1);
        e.active    = 1'b0;
        e.last_disc = e.marker;
        lead.last   = 1'b0;
        tail.last   = 1'b1;
        tail.addr   = e.bits;
        for (int j = 0; j < TABLE_ENTRIES && !matched; j++) begin
          if (e.tbl[j] == '0) begin
            e.tbl[j]    = e.bits;
            tail.status = ST_NEW_STORED;
            tail.slot   = SLOT_W'(j);
            return 2;
          end
          if (e.tbl[j] == e.bits) matched = 1'b1;
        end
        tail.status = (e.last_disc == '0) ? ST_FINISHED : ST_NEXT_PASS;
        return 2;
      end
      CMD_READ_SLOT: begin
        lead.status = ST_SLOT_DATA;
        lead.last   = 1'b1;
        lead.addr   = (w.slot < TABLE_ENTRIES) ? e.tbl[w.slot] : '0;
        return 1;
      end
      CMD_WRITE_SLOT: begin
        if (w.slot < TABLE_ENTRIES) e.tbl[w.slot] = w.value;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bus_word_t make_word(input logic [CMD_W-1:0] cmd, input logic pres,
                                          input logic a, input logic b,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [ADDR_BITS-1:0] value);
    bus_word_t w;
    w.cmd      = cmd;
    w.presence = pres;
    w.a        = a;
    w.b        = b;
    w.slot     = slot;
    w.value    = value;
    return w;
  endfunction

  function automatic string describe(input search_result_t r);
    return $sformatf("status=%0d dir=%0d cmd=%02h addr=%016h slot=%0d last=%0d",
                     r.status, r.dir, r.cbyte, r.addr, r.slot, r.last);
  endfunction

  // Queues a word for the driver; a private copy of the engine tells the bus emulation
  // which direction the engine will pick.
  task automatic issue(input bus_word_t w, output int n,
                       output search_result_t r0, output search_result_t r1);
    n = search_step(gen_engine, w, r0, r1);
    bus_words.push_back(w);
    words_issued++;
    if (n > 0 || w.cmd == CMD_WRITE_SLOT) words_counted++;
  endtask

  // Waits until every queued word is taken and every result word has come back.
  task automatic settle();
    while (words_accepted != words_issued || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_command_byte(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    model_engine.cmd_byte = v;
    gen_engine.cmd_byte   = v;
  endtask

  // Table accesses, unused codes, stray bit pairs and absent presence.
  task automatic random_noise(input bit mid_pass);
    int             n;
    int             kind;
    search_result_t r0;
    search_result_t r1;
    bus_word_t      w;
    w    = make_word(CMD_READ_SLOT, 1'($urandom), 1'($urandom), 1'($urandom),
                     SLOT_W'($urandom), rand64());
    kind = $urandom_range(0, mid_pass ? 2 : 4);
    case (kind)
      0: w.cmd = CMD_READ_SLOT;
      1: w.cmd = CMD_W'($urandom_range(int'(CMD_WRITE_SLOT) + 1, (1 << CMD_W) - 1));
      2: begin
        w.cmd = CMD_WRITE_SLOT;
        if ($urandom_range(0, 1)) w.value = '0;
      end
      3: w.cmd = CMD_BIT_PAIR;
      default: begin
        w.cmd      = $urandom_range(0, 1) ? CMD_NEW_SEARCH : CMD_NEXT_PASS;
        w.presence = 1'b0;
      end
    endcase
    issue(w, n, r0, r1);
  endtask

  // Runs a whole search over the current device population, answering each bit pair
  // as the wired-AND bus would for the devices still following the chosen path.
  // Near the end of the run no further pass is started, so the word count stays close
  // to the target.
  task automatic run_search();
    int               n;
    int               p;
    int               passes;
    int               abort_pass;
    int               abort_bit;
    search_result_t   r0;
    search_result_t   r1;
    logic [MAX_DEVICES-1:0] alive;
    logic             a;
    logic             b;
    bit               done;
    bit               in_pass;
    done       = 1'b0;
    passes     = 0;
    abort_pass = ($urandom_range(0, 5) == 0) ? $urandom_range(0, devices.size()) : -1;
    abort_bit  = $urandom_range(0, ADDR_BITS - 1);
    while (!done && passes < devices.size() + 3 &&
           (passes == 0 || words_counted < ITEM_TARGET)) begin
      issue(make_word(passes == 0 ? CMD_NEW_SEARCH : CMD_NEXT_PASS, 1'b1, 1'($urandom),
                      1'($urandom), SLOT_W'($urandom), rand64()), n, r0, r1);
      alive   = '1;
      p       = 0;
      in_pass = 1'b1;
      while (in_pass) begin
        if ($urandom_range(0, 19) == 0) random_noise(1'b1);
        a = 1'b1;
        b = 1'b1;
        for (int d = 0; d < devices.size(); d++) begin
          if (alive[d]) begin
            a &= devices[d][p];
            b &= ~devices[d][p];
          end
        end
        if ($urandom_range(0, 999) == 0) begin
          a = 1'($urandom);
          b = 1'($urandom);
        end
        if (passes == abort_pass && p == abort_bit) begin
          a = 1'b1;
          b = 1'b1;
        end
        issue(make_word(CMD_BIT_PAIR, 1'($urandom), a, b, SLOT_W'($urandom), rand64()),
              n, r0, r1);
        if (n == 0 || r0.status == ST_READ_ERROR) begin
          in_pass = 1'b0;
          done    = 1'b1;
        end else begin
          for (int d = 0; d < devices.size(); d++)
            if (devices[d][p] != r0.dir) alive[d] = 1'b0;
          if (n == 2) begin
            in_pass = 1'b0;
            if (gen_engine.last_disc == '0) done = 1'b1;
          end
          p++;
        end
      end
      passes++;
    end
  endtask

  // Input side: offers queued words with random gaps and predicts on acceptance.
  always @(posedge clk) begin : word_driver
    int             n;
    search_result_t r0;
    search_result_t r1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        n = search_step(model_engine, word_on_bus, r0, r1);
        if (n > 0) awaited_results.push_back(r0);
        if (n > 1) awaited_results.push_back(r1);
        words_accepted++;
      end
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (bus_words.size() != 0) begin
        word_on_bus = bus_words.pop_front();
        in_tuser  <= word_on_bus.cmd;
        in_tdata  <= {2'b00, word_on_bus.value, word_on_bus.slot, word_on_bus.b,
                      word_on_bus.a, word_on_bus.presence};
        in_tvalid <= 1'b1;
        send_gap  <= pick_gap(tx_idle);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure, with an occasional long hold-off on request.
  always @(posedge clk) begin : result_sink
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait    <= rx_wait - 1;
    end else if (hold_off_req) begin
      out_tready   <= 1'b0;
      rx_wait      <= LONG_HOLD;
      hold_off_req <= 1'b0;
    end else begin
      g = pick_gap(rx_idle);
      out_tready <= (g == 0);
      if (g > 0) rx_wait <= g - 1;
    end
  end

  // Compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    search_result_t got;
    search_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.dir    = out_tdata[0];
      got.cbyte  = out_tdata[8:1];
      got.addr   = out_tdata[72:9];
      got.slot   = out_tdata[75:73];
      got.last   = out_tlast;
      if (awaited_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word: %s", describe(got));
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.status != want.status || got.dir != want.dir || got.cbyte != want.cbyte ||
            got.addr != want.addr || got.slot != want.slot || got.last != want.last) begin
          if (mismatches < 10) begin
            $display("result mismatch at cycle %0d", cycles_run);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int             n;
    int             round;
    int             ndev;
    search_result_t r0;
    search_result_t r1;
    logic [ADDR_BITS-1:0] base;
    logic [7:0]     cmd_value;
    model_engine = engine_reset();
    gen_engine   = engine_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: empty table reads, ignored codes, missing presence, table extremes,
    // a restarted pass and a read error, all with the reset command byte.
    issue(make_word(CMD_READ_SLOT, 1'b1, 1'b1, 1'b1, '0, '1), n, r0, r1);
    issue(make_word(CMD_READ_SLOT, 1'b0, 1'b0, 1'b0, '1, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b0, '0, '0), n, r0, r1);
    for (int c = int'(CMD_WRITE_SLOT) + 1; c < (1 << CMD_W); c++)
      issue(make_word(CMD_W'(c), 1'b1, 1'b1, 1'b1, '1, '1), n, r0, r1);
    issue(make_word(CMD_NEW_SEARCH, 1'b0, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_NEXT_PASS, 1'b0, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_WRITE_SLOT, 1'b0, 1'b0, 1'b0, '1, '1), n, r0, r1);
    issue(make_word(CMD_READ_SLOT, 1'b0, 1'b0, 1'b0, '1, '0), n, r0, r1);
    issue(make_word(CMD_WRITE_SLOT, 1'b0, 1'b0, 1'b0, '0, 64'h1), n, r0, r1);
    issue(make_word(CMD_READ_SLOT, 1'b0, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_NEW_SEARCH, 1'b1, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b1, '0, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_NEXT_PASS, 1'b1, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b0, '0, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b1, '0, '0), n, r0, r1);
    issue(make_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b1, '0, '0), n, r0, r1);
    issue(make_word(CMD_WRITE_SLOT, 1'b0, 1'b0, 1'b0, '1, '0), n, r0, r1);
    issue(make_word(CMD_WRITE_SLOT, 1'b0, 1'b0, 1'b0, '0, '0), n, r0, r1);

    // Random rounds: each one drains, changes the command byte, then runs a search.
    round = 0;
    while (words_counted < ITEM_TARGET) begin
      settle();
      case (round % 4)
        0: cmd_value = 8'h00;
        1: cmd_value = 8'hFF;
        2: cmd_value = 8'hEC;
        default: cmd_value = 8'($urandom);
      endcase
      write_command_byte(cmd_value);
      tx_idle <= ($urandom_range(0, 3) != 0);
      rx_idle <= ($urandom_range(0, 3) != 0);
      if (round == 1 || $urandom_range(0, 5) == 0) hold_off_req <= 1'b1;
      if (round % 3 == 2) begin
        for (int s = 0; s < TABLE_ENTRIES; s++)
          if ($urandom_range(0, 1))
            issue(make_word(CMD_WRITE_SLOT, 1'($urandom), 1'($urandom), 1'($urandom),
                            SLOT_W'(s), '0), n, r0, r1);
      end
      repeat ($urandom_range(2, 6)) random_noise(1'b0);

      // Device population: the all-zero and all-one addresses early on, then groups
      // that share most bits so that the search meets many discrepancies.
      devices.delete();
      if (round == 0) begin
        devices.push_back('0);
      end else if (round == 1) begin
        devices.push_back('1);
        devices.push_back('0);
        devices.push_back(64'h8000_0000_0000_0000);
      end else begin
        ndev = ($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_DEVICES)
                                           : $urandom_range(1, 4);
        base = rand64();
        repeat (ndev) begin
          if ($urandom_range(0, 3) == 0) devices.push_back(rand64());
          else devices.push_back(base ^ (rand64() & rand64() & rand64()));
        end
      end
      run_search();
      repeat ($urandom_range(1, 4)) random_noise(1'b0);
      round++;
    end

    settle();
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
design/owse_pkg.sv
design/onewire_rom_search_engine_unit.sv
verif/tb_onewire_rom_search_engine_unit.sv
